>>> rtl/core/cuvp_pkg.sv
// Shared types and constants for the unit-vector-to-pixel projection core.
package cuvp_pkg;

    localparam int POLY_ORDER = 5;
    localparam int TBL_DEPTH  = POLY_ORDER * POLY_ORDER;
    localparam int TBL_AW     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int KW         = (POLY_ORDER > 1) ? $clog2(POLY_ORDER) : 1;

    localparam int DIR_W  = 18;
    localparam int COEF_W = 32;
    localparam int PIX_W  = 20;
    localparam int IDX_W  = 5;

    // ratio divider: |x| << 22 plus z/2, one quotient bit per cycle
    localparam int DIV_W  = 40;
    localparam int DIV_CW = $clog2(DIV_W + 1);
    localparam int ZW     = DIR_W - 1;
    localparam int XN_W   = 25;              // Q2.22 ratio, +-2.0
    localparam int PW     = 23 + POLY_ORDER; // powers of the ratio, Q.22
    localparam int MW     = 22 + 2 * POLY_ORDER; // monomials, Q.22
    localparam int ACC_W  = MW + 6;
    localparam int LIN_W  = 28;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 24;
    localparam logic [CFG_IW-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_WIDTH  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_HEIGHT = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_FX     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_FY     = 3'd4;

    localparam logic [0:0] ACT_PROJECT = 1'b0;
    localparam logic [0:0] ACT_LOAD    = 1'b1;
    localparam logic [0:0] AXIS_U      = 1'b0;

    localparam logic [23:0] RATIO_LIMIT = 24'h800000;

    typedef struct packed {
        logic          load_coef;
        logic          init;
        logic          div_step;
        logic          ratio;
        logic          lin_mul;
        logic          lin_add;
        logic          pow_step;
        logic          mono;
        logic          term_mul;
        logic          term_acc;
        logic          out_load;
        logic [KW-1:0] idx_k;
        logic [KW-1:0] idx_j;
    } cmd_t;

    typedef struct packed {
        logic z_nonpos;
        logic poly_mode;
    } sts_t;

endpackage

>>> rtl/core/camera_unit_vector_to_pixel_core.sv
// Top level of the camera direction to pixel projection core.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    action, dir_x/y/z, coeff_axis/index/value
//  m_        out        m_valid/m_ready    pixel_u, pixel_v, behind_camera, saturated
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (write only)
//
// Load transfer: no result. Project transfer, z > 0: the divider works out x/z
// and y/z in parallel, one quotient bit per cycle, then a ratio step follows;
// linear: a multiply step and an add step; polynomial: the power steps, then a
// monomial, a coefficient multiply and an accumulate step per table term. The
// output register is loaded last, and then the core returns to idle. z <= 0 goes
// straight to the output register. Reset (aresetn low, synchronous) restores
// the config registers and marks all coefficient entries as zero. s_ready is
// high only while idle; a finished result waits in the output register while
// m_ready is low, and the next item can be accepted as soon as it is stored
// there.
module camera_unit_vector_to_pixel_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [cuvp_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [cuvp_pkg::CFG_DW-1:0]          cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic signed [cuvp_pkg::DIR_W-1:0]    s_dir_x,
    input  logic signed [cuvp_pkg::DIR_W-1:0]    s_dir_y,
    input  logic signed [cuvp_pkg::DIR_W-1:0]    s_dir_z,
    input  logic                                 s_coeff_axis,
    input  logic [cuvp_pkg::IDX_W-1:0]           s_coeff_index,
    input  logic signed [cuvp_pkg::COEF_W-1:0]   s_coeff_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [cuvp_pkg::PIX_W-1:0]    m_pixel_u,
    output logic signed [cuvp_pkg::PIX_W-1:0]    m_pixel_v,
    output logic                                 m_behind_camera,
    output logic                                 m_saturated
);

    cuvp_pkg::cmd_t cmd;
    cuvp_pkg::sts_t sts;

    // sequencer: state, step counters, output valid
    cuvp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: config, tables, divider, multipliers, output register
    cuvp_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_dir_x         (s_dir_x),
        .s_dir_y         (s_dir_y),
        .s_dir_z         (s_dir_z),
        .s_coeff_axis    (s_coeff_axis),
        .s_coeff_index   (s_coeff_index),
        .s_coeff_value   (s_coeff_value),
        .m_pixel_u       (m_pixel_u),
        .m_pixel_v       (m_pixel_v),
        .m_behind_camera (m_behind_camera),
        .m_saturated     (m_saturated),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

>>> rtl/core/cuvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cuvp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 25
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/cuvp_ctrl.sv
// Sequencer for the projection core: divide, ratio, linear or polynomial pass.
module cuvp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    output logic               m_valid,
    input  logic               m_ready,
    input  cuvp_pkg::sts_t     sts,
    output cuvp_pkg::cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV      = 4'd1;
    localparam logic [3:0] ST_RATIO    = 4'd2;
    localparam logic [3:0] ST_LIN_MUL  = 4'd3;
    localparam logic [3:0] ST_LIN_ADD  = 4'd4;
    localparam logic [3:0] ST_POW      = 4'd5;
    localparam logic [3:0] ST_MONO     = 4'd6;
    localparam logic [3:0] ST_TERM_MUL = 4'd7;
    localparam logic [3:0] ST_TERM_ACC = 4'd8;
    localparam logic [3:0] ST_FINISH   = 4'd9;

    localparam logic [cuvp_pkg::KW-1:0] K_LAST = cuvp_pkg::KW'(cuvp_pkg::POLY_ORDER - 1);

    logic [3:0]                    state_reg, state_next;
    logic [cuvp_pkg::DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [cuvp_pkg::KW-1:0]       k_reg, k_next, j_reg, j_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        cmd          = '0;
        cmd.idx_k    = k_reg;
        cmd.idx_j    = j_reg;
        cmd.load_coef = accept && (s_action == cuvp_pkg::ACT_LOAD);
        cmd.init      = accept && (s_action == cuvp_pkg::ACT_PROJECT);
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.init) begin
                    state_next = sts.z_nonpos ? ST_FINISH : ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == cuvp_pkg::DIV_CW'(cuvp_pkg::DIV_W - 1)) begin
                    state_next = ST_RATIO;
                end
            end
            ST_RATIO: begin
                cmd.ratio = 1'b1;
                cnt_next  = cuvp_pkg::DIV_CW'(1);
                k_next    = '0;
                j_next    = '0;
                if (!sts.poly_mode) begin
                    state_next = ST_LIN_MUL;
                end else if (cuvp_pkg::POLY_ORDER > 1) begin
                    state_next = ST_POW;
                end else begin
                    state_next = ST_MONO;
                end
            end
            ST_LIN_MUL: begin
                cmd.lin_mul = 1'b1;
                state_next  = ST_LIN_ADD;
            end
            ST_LIN_ADD: begin
                cmd.lin_add = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_POW: begin
                cmd.pow_step = 1'b1;
                cmd.idx_k    = cnt_reg[cuvp_pkg::KW-1:0];
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg[cuvp_pkg::KW-1:0] == K_LAST) begin
                    state_next = ST_MONO;
                end
            end
            ST_MONO: begin
                cmd.mono   = 1'b1;
                state_next = ST_TERM_MUL;
            end
            ST_TERM_MUL: begin
                cmd.term_mul = 1'b1;
                state_next   = ST_TERM_ACC;
            end
            ST_TERM_ACC: begin
                cmd.term_acc = 1'b1;
                state_next   = ST_MONO;
                if (j_reg == K_LAST) begin
                    j_next = '0;
                    if (k_reg == K_LAST) begin
                        state_next = ST_FINISH;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            k_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> rtl/core/cuvp_dp.sv
// Datapath: config registers, coefficient tables, divider, multipliers, output register.
module cuvp_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [cuvp_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [cuvp_pkg::CFG_DW-1:0]          cfg_wdata,
    input  logic signed [cuvp_pkg::DIR_W-1:0]    s_dir_x,
    input  logic signed [cuvp_pkg::DIR_W-1:0]    s_dir_y,
    input  logic signed [cuvp_pkg::DIR_W-1:0]    s_dir_z,
    input  logic                                 s_coeff_axis,
    input  logic [cuvp_pkg::IDX_W-1:0]           s_coeff_index,
    input  logic signed [cuvp_pkg::COEF_W-1:0]   s_coeff_value,
    output logic signed [cuvp_pkg::PIX_W-1:0]    m_pixel_u,
    output logic signed [cuvp_pkg::PIX_W-1:0]    m_pixel_v,
    output logic                                 m_behind_camera,
    output logic                                 m_saturated,
    input  cuvp_pkg::cmd_t                       cmd,
    output cuvp_pkg::sts_t                       sts
);

    localparam int DW = cuvp_pkg::DIV_W;
    localparam int ZW = cuvp_pkg::ZW;
    localparam int PW = cuvp_pkg::PW;
    localparam int MW = cuvp_pkg::MW;
    localparam int XW = cuvp_pkg::XN_W;
    localparam int AW = cuvp_pkg::ACC_W;
    localparam int LW = cuvp_pkg::LIN_W;
    localparam int TW = cuvp_pkg::TBL_AW;
    localparam int CW = cuvp_pkg::COEF_W;

    localparam logic signed [PW+XW-1:0] HALF_P = (PW+XW)'(64'sd1 << 21);
    localparam logic signed [2*PW-1:0]  HALF_M = (2*PW)'(64'sd1 << 21);
    localparam logic signed [CW+MW-1:0] HALF_T = (CW+MW)'(64'sd1 << 31);
    localparam logic signed [2*XW-1:0]  HALF_L = (2*XW)'(64'sd1 << 23);
    localparam logic signed [AW-1:0]    OUT_MAX = AW'(64'sd524287);
    localparam logic signed [AW-1:0]    OUT_MIN = AW'(-64'sd524288);

    // configuration
    logic        mode_reg;
    logic [13:0] width_reg, height_reg;
    logic [23:0] fx_reg, fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            width_reg  <= 14'd1024;
            height_reg <= 14'd1024;
            fx_reg     <= 24'd262144;
            fy_reg     <= 24'd262144;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cuvp_pkg::CFG_MODE:   mode_reg   <= cfg_wdata[0];
                cuvp_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[13:0];
                cuvp_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[13:0];
                cuvp_pkg::CFG_FX:     fx_reg     <= cfg_wdata;
                cuvp_pkg::CFG_FY:     fy_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign sts.poly_mode = mode_reg;
    assign sts.z_nonpos  = s_dir_z[cuvp_pkg::DIR_W-1] || (s_dir_z == '0);

    // coefficient tables; entries never written read as zero
    logic                             idx_ok, we_u, we_v;
    logic [TW-1:0]                    waddr, raddr;
    logic [cuvp_pkg::TBL_DEPTH-1:0]   vld_u_reg, vld_v_reg;
    logic                             rdv_u_reg, rdv_v_reg;
    logic [CW-1:0]                    rd_u, rd_v;
    logic signed [CW-1:0]             cu, cv;

    assign idx_ok = 32'(s_coeff_index) < cuvp_pkg::TBL_DEPTH;
    assign waddr  = TW'(s_coeff_index);
    assign we_u   = cmd.load_coef && idx_ok && (s_coeff_axis == cuvp_pkg::AXIS_U);
    assign we_v   = cmd.load_coef && idx_ok && (s_coeff_axis != cuvp_pkg::AXIS_U);
    assign raddr  = TW'(32'(cmd.idx_k) * cuvp_pkg::POLY_ORDER + 32'(cmd.idx_j));

    cuvp_ram #(.WIDTH(CW), .DEPTH(cuvp_pkg::TBL_DEPTH)) u_ram_u (
        .aclk(aclk), .we(we_u), .waddr(waddr), .wdata(s_coeff_value),
        .raddr(raddr), .rdata(rd_u)
    );
    cuvp_ram #(.WIDTH(CW), .DEPTH(cuvp_pkg::TBL_DEPTH)) u_ram_v (
        .aclk(aclk), .we(we_v), .waddr(waddr), .wdata(s_coeff_value),
        .raddr(raddr), .rdata(rd_v)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_u_reg <= '0;
            vld_v_reg <= '0;
            rdv_u_reg <= 1'b0;
            rdv_v_reg <= 1'b0;
        end else begin
            if (we_u) vld_u_reg[waddr] <= 1'b1;
            if (we_v) vld_v_reg[waddr] <= 1'b1;
            rdv_u_reg <= vld_u_reg[raddr];
            rdv_v_reg <= vld_v_reg[raddr];
        end
    end

    assign cu = rdv_u_reg ? $signed(rd_u) : '0;
    assign cv = rdv_v_reg ? $signed(rd_v) : '0;

    // ratio dividers, restoring, one bit per cycle
    localparam int DIR_W_M = cuvp_pkg::DIR_W - 1;
    logic [ZW-1:0]   z_reg;
    logic [ZW-1:0]   rem_x_reg, rem_y_reg;
    logic [DW-1:0]   nq_x_reg, nq_y_reg;
    logic            neg_x_reg, neg_y_reg, behind_reg, sat_reg;
    logic [DIR_W_M:0] mag_x, mag_y;
    logic [ZW+1:0]   tr_x, tr_y;
    logic [23:0]     qc_x, qc_y;
    logic            qs_x, qs_y;

    assign mag_x = s_dir_x[DIR_W_M] ? cuvp_pkg::DIR_W'(-s_dir_x) : s_dir_x;
    assign mag_y = s_dir_y[DIR_W_M] ? cuvp_pkg::DIR_W'(-s_dir_y) : s_dir_y;
    assign tr_x  = {1'b0, rem_x_reg, nq_x_reg[DW-1]} - {2'b00, z_reg};
    assign tr_y  = {1'b0, rem_y_reg, nq_y_reg[DW-1]} - {2'b00, z_reg};

    assign qs_x = (|nq_x_reg[DW-1:24]) || (nq_x_reg[23:0] > cuvp_pkg::RATIO_LIMIT);
    assign qs_y = (|nq_y_reg[DW-1:24]) || (nq_y_reg[23:0] > cuvp_pkg::RATIO_LIMIT);
    assign qc_x = qs_x ? cuvp_pkg::RATIO_LIMIT : nq_x_reg[23:0];
    assign qc_y = qs_y ? cuvp_pkg::RATIO_LIMIT : nq_y_reg[23:0];

    logic signed [XW-1:0] xn_reg, yn_reg;

    // powers, monomial, products
    logic signed [PW-1:0]      xp_reg [cuvp_pkg::POLY_ORDER];
    logic signed [PW-1:0]      yp_reg [cuvp_pkg::POLY_ORDER];
    logic [cuvp_pkg::KW-1:0]   km1;
    logic signed [PW+XW-1:0]   px, py;
    logic signed [2*PW-1:0]    pm;
    logic signed [MW-1:0]      mono_reg;
    logic signed [CW+MW-1:0]   pu_reg, pv_reg;
    logic signed [AW-1:0]      acc_u_reg, acc_v_reg;
    logic signed [2*XW-1:0]    lu_reg, lv_reg;
    logic signed [LW-1:0]      lin_u_reg, lin_v_reg;

    assign km1 = cmd.idx_k - 1'b1;
    assign px  = xp_reg[km1] * xn_reg;
    assign py  = yp_reg[km1] * yn_reg;
    assign pm  = xp_reg[cmd.idx_k] * yp_reg[cmd.idx_j];

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            z_reg      <= s_dir_z[ZW-1:0];
            rem_x_reg  <= '0;
            rem_y_reg  <= '0;
            nq_x_reg   <= {mag_x, 22'd0} + DW'(s_dir_z[ZW-1:1]);
            nq_y_reg   <= {mag_y, 22'd0} + DW'(s_dir_z[ZW-1:1]);
            neg_x_reg  <= s_dir_x[DIR_W_M];
            neg_y_reg  <= s_dir_y[DIR_W_M];
            behind_reg <= sts.z_nonpos;
            sat_reg    <= 1'b0;
            acc_u_reg  <= '0;
            acc_v_reg  <= '0;
            xp_reg[0]  <= PW'(64'sd1 << 22);
            yp_reg[0]  <= PW'(64'sd1 << 22);
        end
        if (cmd.div_step) begin
            if (!tr_x[ZW+1]) begin
                rem_x_reg <= tr_x[ZW-1:0];
            end else begin
                rem_x_reg <= {rem_x_reg[ZW-2:0], nq_x_reg[DW-1]};
            end
            if (!tr_y[ZW+1]) begin
                rem_y_reg <= tr_y[ZW-1:0];
            end else begin
                rem_y_reg <= {rem_y_reg[ZW-2:0], nq_y_reg[DW-1]};
            end
            nq_x_reg <= {nq_x_reg[DW-2:0], !tr_x[ZW+1]};
            nq_y_reg <= {nq_y_reg[DW-2:0], !tr_y[ZW+1]};
        end
        if (cmd.ratio) begin
            xn_reg  <= neg_x_reg ? -$signed({1'b0, qc_x}) : $signed({1'b0, qc_x});
            yn_reg  <= neg_y_reg ? -$signed({1'b0, qc_y}) : $signed({1'b0, qc_y});
            sat_reg <= qs_x || qs_y;
        end
        if (cmd.lin_mul) begin
            lu_reg <= $signed({1'b0, fx_reg}) * xn_reg;
            lv_reg <= $signed({1'b0, fy_reg}) * yn_reg;
        end
        if (cmd.lin_add) begin
            lin_u_reg <= LW'((lu_reg + HALF_L) >>> 24) + $signed(LW'({width_reg, 5'd0}));
            lin_v_reg <= LW'((lv_reg + HALF_L) >>> 24) + $signed(LW'({height_reg, 5'd0}));
        end
        if (cmd.pow_step) begin
            xp_reg[cmd.idx_k] <= PW'((px + HALF_P) >>> 22);
            yp_reg[cmd.idx_k] <= PW'((py + HALF_P) >>> 22);
        end
        if (cmd.mono) begin
            mono_reg <= MW'((pm + HALF_M) >>> 22);
        end
        if (cmd.term_mul) begin
            pu_reg <= cu * mono_reg;
            pv_reg <= cv * mono_reg;
        end
        if (cmd.term_acc) begin
            acc_u_reg <= acc_u_reg + AW'((pu_reg + HALF_T) >>> 32);
            acc_v_reg <= acc_v_reg + AW'((pv_reg + HALF_T) >>> 32);
        end
    end

    // final select and clip
    localparam int PIX_W_M = cuvp_pkg::PIX_W - 1;
    logic signed [AW-1:0]    pre_u, pre_v;
    logic                    hi_u, lo_u, hi_v, lo_v;
    logic signed [PIX_W_M:0] out_u_reg, out_v_reg;
    logic                    out_b_reg, out_s_reg;

    assign pre_u = mode_reg ? acc_u_reg : AW'(lin_u_reg);
    assign pre_v = mode_reg ? acc_v_reg : AW'(lin_v_reg);
    assign hi_u  = pre_u > OUT_MAX;
    assign lo_u  = pre_u < OUT_MIN;
    assign hi_v  = pre_v > OUT_MAX;
    assign lo_v  = pre_v < OUT_MIN;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_b_reg <= behind_reg;
            if (behind_reg) begin
                out_u_reg <= '0;
                out_v_reg <= '0;
                out_s_reg <= 1'b0;
            end else begin
                out_u_reg <= hi_u ? cuvp_pkg::PIX_W'(OUT_MAX) :
                             lo_u ? cuvp_pkg::PIX_W'(OUT_MIN) : cuvp_pkg::PIX_W'(pre_u);
                out_v_reg <= hi_v ? cuvp_pkg::PIX_W'(OUT_MAX) :
                             lo_v ? cuvp_pkg::PIX_W'(OUT_MIN) : cuvp_pkg::PIX_W'(pre_v);
                out_s_reg <= sat_reg || hi_u || lo_u || hi_v || lo_v;
            end
        end
    end

    assign m_pixel_u       = out_u_reg;
    assign m_pixel_v       = out_v_reg;
    assign m_behind_camera = out_b_reg;
    assign m_saturated     = out_s_reg;

endmodule

>>> rtl/core/cuvp_chk.sv
// Port-level checker for the projection core, bound to the top level.
module cuvp_chk (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 s_action,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [cuvp_pkg::PIX_W-1:0]    m_pixel_u,
    input logic signed [cuvp_pkg::PIX_W-1:0]    m_pixel_v,
    input logic                                 m_behind_camera,
    input logic                                 m_saturated
);

    // a result held back keeps its valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // behind-camera results carry zero pixels and no clip flag
    a_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_behind_camera |-> m_pixel_u == '0 && m_pixel_v == '0 && !m_saturated)
        else $error("behind-camera result not zeroed");

    // a project transfer occupies the core for at least the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == cuvp_pkg::ACT_PROJECT) |=> !s_ready)
        else $error("input accepted while projection in flight");

    // a load transfer never produces a result by itself
    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == cuvp_pkg::ACT_LOAD) && !m_valid |=> !m_valid)
        else $error("result after coefficient load");

endmodule

bind camera_unit_vector_to_pixel_core cuvp_chk u_cuvp_chk (.*);
